/* design/ortl_pkg.sv */
// ----------------------------------------------------------------------------
// ortl_pkg
// Shared types, constants and helpers of the ordered route table lookup.
// ----------------------------------------------------------------------------
package ortl_pkg;

  localparam int ENTRIES    = 16;
  localparam int PORT_BITS  = 4;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int PORT_EXT_W = (PORT_BITS > 4) ? PORT_BITS : 4;
  localparam int CNT_EXT_W  = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DEL    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DEL,
    OP_LOOKUP,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    op_e                  op;
    logic [31:0]          address;
    logic [31:0]          netmask;
    logic [31:0]          next_hop;
    logic [PORT_BITS-1:0] port;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        hit_default;
    logic [31:0] hit_gateway;
    logic [31:0] hit_mask;
    logic [3:0]  hit_port;
    logic [4:0]  route_count;
  } rsp_t;

  function automatic logic [PORT_BITS-1:0] port_store(logic [3:0] p);
    logic [PORT_EXT_W-1:0] e;
    e = PORT_EXT_W'(p);
    return e[PORT_BITS-1:0];
  endfunction

  function automatic logic [3:0] port_load(logic [PORT_BITS-1:0] s);
    logic [PORT_EXT_W-1:0] e;
    e = PORT_EXT_W'(s);
    return e[3:0];
  endfunction

  function automatic logic [4:0] count_out(logic [CNT_W-1:0] c);
    logic [CNT_EXT_W-1:0] e;
    e = CNT_EXT_W'(c);
    return e[4:0];
  endfunction

endpackage

/* design/ortl_front.sv */
// ----------------------------------------------------------------------------
// ortl_front
// Accepts items, decodes the command and holds them in a short queue.
// ----------------------------------------------------------------------------
module ortl_front import ortl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_cmd_i,
  input  logic [31:0] in_address_i,
  input  logic [31:0] in_netmask_i,
  input  logic [31:0] in_next_hop_i,
  input  logic [3:0]  in_port_i,
  output logic        req_valid_o,
  output req_t        req_o,
  input  logic        req_pop_i
);

  req_t              q_mem [QDEPTH];
  req_t              in_req;
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push, pop;

  always_comb begin
    in_req          = '0;
    in_req.address  = in_address_i;
    in_req.netmask  = in_netmask_i;
    in_req.next_hop = in_next_hop_i;
    in_req.port     = port_store(in_port_i);
    unique case (in_cmd_i)
      CMD_ADD:    in_req.op = OP_ADD;
      CMD_DEL:    in_req.op = OP_DEL;
      CMD_LOOKUP: in_req.op = OP_LOOKUP;
      default:    in_req.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != QCNT_W'(QDEPTH));
  assign req_valid_o = (fill_q != '0);
  assign req_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_pop_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_req;
    end
  end

endmodule

/* design/ortl_back.sv */
// ----------------------------------------------------------------------------
// ortl_back
// Holds the route table, matches each queued item against all entries and
// carries out add, delete and lookup; drives the result register.
// ----------------------------------------------------------------------------
module ortl_back import ortl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  req_t req_i,
  output logic req_pop_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o,
  input  logic rsp_ready_i
);

  bk_state_e            state_q, state_d;
  req_t                 cur_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [31:0]          dest_q [ENTRIES];
  logic [31:0]          mask_q [ENTRIES];
  logic [31:0]          gw_q   [ENTRIES];
  logic [PORT_BITS-1:0] port_q [ENTRIES];
  logic [ENTRIES-1:0]   hit_vec, hit_vec_q;
  logic [ENTRIES-1:0]   dflt_vec, dflt_vec_q;
  logic                 dup_any, dup_q;
  rsp_t                 rsp_q, rsp_d;
  logic                 rsp_valid_q;
  logic                 load_cur, match_en, exec_fire;
  logic [IDX_W-1:0]     hit_idx, dflt_idx, sel_idx;
  logic                 any_hit, any_dflt, found;
  logic                 do_append, do_remove;

  always_comb begin
    dup_any = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      logic live;
      live        = (CNT_W'(i) < count_q);
      hit_vec[i]  = live && (dest_q[i] != '0) &&
                    ((cur_q.address & mask_q[i]) == dest_q[i]);
      dflt_vec[i] = live && (dest_q[i] == '0);
      dup_any     = dup_any | (live && (dest_q[i] == cur_q.address));
    end
  end

  always_comb begin
    hit_idx  = '0;
    dflt_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec_q[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (dflt_vec_q[i]) begin
        dflt_idx = IDX_W'(i);
      end
    end
    any_hit  = |hit_vec_q;
    any_dflt = |dflt_vec_q;
    found    = any_hit || any_dflt;
    sel_idx  = any_hit ? hit_idx : dflt_idx;
  end

  always_comb begin
    rsp_d     = '0;
    do_append = 1'b0;
    do_remove = 1'b0;
    count_d   = count_q;
    rsp_d.status = ST_OK;
    case (cur_q.op)
      OP_ADD: begin
        if (dup_q) begin
          rsp_d.status = ST_DUP;
        end else if (count_q == CNT_W'(ENTRIES)) begin
          rsp_d.status = ST_FULL;
        end else begin
          do_append = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OP_DEL: begin
        if (found) begin
          do_remove         = 1'b1;
          rsp_d.hit_default = !any_hit;
          count_d           = count_q - 1'b1;
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          rsp_d.hit_default = !any_hit;
          rsp_d.hit_gateway = gw_q[sel_idx];
          rsp_d.hit_mask    = mask_q[sel_idx];
          rsp_d.hit_port    = port_load(port_q[sel_idx]);
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      default: ;
    endcase
    rsp_d.route_count = count_out(count_d);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (req_valid_i) state_d = BK_MATCH;
      BK_MATCH: state_d = BK_EXEC;
      BK_EXEC:  if (!rsp_valid_q || rsp_ready_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    load_cur  = 1'b0;
    match_en  = 1'b0;
    exec_fire = 1'b0;
    unique case (state_q)
      BK_IDLE:  load_cur  = req_valid_i;
      BK_MATCH: match_en  = 1'b1;
      BK_EXEC:  exec_fire = !rsp_valid_q || rsp_ready_i;
      default: ;
    endcase
  end

  assign req_pop_o   = load_cur;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cur) begin
      cur_q <= req_i;
    end
    if (match_en) begin
      hit_vec_q  <= hit_vec;
      dflt_vec_q <= dflt_vec;
      dup_q      <= dup_any;
    end
    if (exec_fire) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire && do_append) begin
      dest_q[count_q[IDX_W-1:0]] <= cur_q.address;
      mask_q[count_q[IDX_W-1:0]] <= cur_q.netmask;
      gw_q[count_q[IDX_W-1:0]]   <= cur_q.next_hop;
      port_q[count_q[IDX_W-1:0]] <= cur_q.port;
    end
    for (int i = 0; i < ENTRIES - 1; i++) begin
      // shift the tail down over the removed entry
      if (exec_fire && do_remove && (IDX_W'(i) >= sel_idx)) begin
        dest_q[i] <= dest_q[i+1];
        mask_q[i] <= mask_q[i+1];
        gw_q[i]   <= gw_q[i+1];
        port_q[i] <= port_q[i+1];
      end
    end
  end

endmodule

/* design/ordered_route_table_lookup.sv */
// ----------------------------------------------------------------------------
// ordered_route_table_lookup
// Ordered IPv4 route table with first-match lookup, add and delete.
// ----------------------------------------------------------------------------
// Each item goes through the table sequencer states in order: take it from
// the input queue, compare the address against every entry in parallel and
// register the match vectors, then pick the entry by priority, update the
// table and load the result register. The sequencer takes a new item
// only once the last one is through; the two-item input queue and the result
// register let either side stall on its own. The table starts empty and
// needs no clearing pass after reset.
module ordered_route_table_lookup import ortl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address, netmask, next_hop, port_number, zero fill
  input  logic [103:0] s_axis_tdata,
  // cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, hit_default, hit_gateway, hit_mask, hit_port, route_count, zero fill
  output logic [79:0]  m_axis_tdata
);

  req_t req;
  logic req_valid, req_pop;
  rsp_t rsp;

  ortl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_address_i  (s_axis_tdata[31:0]),
    .in_netmask_i  (s_axis_tdata[63:32]),
    .in_next_hop_i (s_axis_tdata[95:64]),
    .in_port_i     (s_axis_tdata[99:96]),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_pop_i     (req_pop)
  );

  ortl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_o       (rsp),
    .rsp_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, rsp.route_count, rsp.hit_port, rsp.hit_mask,
                         rsp.hit_gateway, rsp.hit_default, rsp.status};

endmodule
